// ===== sv/tbg_pkg.sv =====
// ----------------------------------------------------------------------------
// tbg_pkg
// constants, types and helpers shared by the three-body step block
// ----------------------------------------------------------------------------
`default_nettype none
package tbg_pkg;
  localparam int FRAC_BITS = 16;
  localparam int NBODY = 3;
  localparam int NCOORD = 9;

  // 66.743 in fixed point, truncated
  localparam logic [30:0] GRAV_RESET = 31'((64'sd66743 <<< FRAC_BITS) / 64'sd1000);

  localparam logic [2:0] REG_MASS0 = 3'd0;
  localparam logic [2:0] REG_MASS1 = 3'd1;
  localparam logic [2:0] REG_MASS2 = 3'd2;
  localparam logic [2:0] REG_GRAV  = 3'd3;
  localparam logic [2:0] REG_STOP  = 3'd4;

  // datapath opcodes, issued by the sequencer
  typedef enum logic [3:0] {
    OP_NOP,     // idle
    OP_START,   // latch dt, finished flag
    OP_PAIR,    // load pair difference, sum of squares, start sqrt
    OP_GM1,     // gm = G*mi
    OP_GM2,     // gm = gm*mj
    OP_DIV,     // start a divide (sel picks operands)
    OP_FMUL,    // force component from unit vector and q
    OP_ACC,     // start the force sum divide by mass
    OP_VEL,     // velocity update
    OP_POS      // position update
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] pair;   // 0: 0-1, 1: 0-2, 2: 1-2
    logic [1:0] body;
    logic [1:0] comp;
    logic [2:0] dsel;   // divide operand select
  } cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
    logic n_zero;
  } stat_t;

  localparam logic [2:0] DS_Q1   = 3'd0;
  localparam logic [2:0] DS_Q2   = 3'd1;
  localparam logic [2:0] DS_U    = 3'd2;
  localparam logic [2:0] DS_A    = 3'd3;
  localparam logic [2:0] DS_NONE = 3'd7;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] init_pos(input logic [3:0] k);
    logic signed [31:0] r;
    case (k)
      4'd0: r = -(32'sd10 <<< FRAC_BITS);
      4'd3: r = 32'sd10 <<< FRAC_BITS;
      4'd7: r = 32'sd5 <<< FRAC_BITS;
      4'd8: r = 32'sd10 <<< FRAC_BITS;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] init_vel(input logic [3:0] k);
    logic signed [31:0] r;
    case (k)
      4'd1: r = 32'sd1 <<< FRAC_BITS;
      4'd4: r = -(32'sd1 <<< FRAC_BITS);
      4'd6: r = 32'sd1 <<< FRAC_BITS;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== sv/tbg_sqrt.sv =====
// ----------------------------------------------------------------------------
// tbg_sqrt
// bit-pair iterative integer square root of a 66-bit value, 33 steps
// ----------------------------------------------------------------------------
`default_nettype none
module tbg_sqrt import tbg_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [65:0] radicand,
  output logic             busy,
  output logic [32:0]      root
);
  logic [65:0] rem;
  logic [65:0] rad;
  logic [5:0]  cnt;
  logic [67:0] trial;
  logic [67:0] rem_sh;

  always_comb begin
    rem_sh = {rem, rad[65:64]};
    trial  = {33'd0, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd33;
      rem  <= '0;
      rad  <= radicand;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[63:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= 66'(rem_sh - trial);
        root <= {root[31:0], 1'b1};
      end else begin
        rem  <= rem_sh[65:0];
        root <= {root[31:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== sv/tbg_div.sv =====
// ----------------------------------------------------------------------------
// tbg_div
// signed restoring divider, truncates toward zero, one quotient bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none
module tbg_div import tbg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic [32:0]        den,
  output logic                    busy,
  output logic signed [64:0]      quo
);
  logic [63:0] mag;
  logic [63:0] q;
  logic [33:0] rem;
  logic        neg;
  logic [6:0]  cnt;
  logic [33:0] rem_sh;
  logic [32:0] dreg;

  assign rem_sh = {rem[32:0], mag[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
      neg  <= num[63];
      mag  <= num[63] ? 64'(-num) : 64'(num);
      rem  <= '0;
      q    <= '0;
      dreg <= den;
    end else if (busy) begin
      mag <= {mag[62:0], 1'b0};
      if (rem_sh >= {1'b0, dreg}) begin
        rem <= rem_sh - {1'b0, dreg};
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) busy <= 1'b0;
    end
  end

  assign quo = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
endmodule
`default_nettype wire

// ===== sv/tbg_datapath.sv =====
// ----------------------------------------------------------------------------
// tbg_datapath
// state registers, pair force and integration arithmetic for the step
// ----------------------------------------------------------------------------
`default_nettype none
module tbg_datapath import tbg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic signed [31:0] elapsed_time,
  input  wire cmd_t               cmd,
  output stat_t                   stat,
  output logic signed [31:0]      pos_b [3],
  output logic signed [31:0]      acc_b [3],
  output logic                    fin
);
  logic [30:0] mass [NBODY];
  logic [30:0] grav_const;
  logic [30:0] stop_time;
  logic signed [31:0] pos [NCOORD];
  logic signed [31:0] vel [NCOORD];
  logic signed [31:0] acc [NCOORD];
  logic signed [31:0] last_time;
  logic signed [31:0] dt;
  logic signed [31:0] tin;
  logic signed [31:0] r [3];
  logic signed [31:0] f [3][3];   // per pair, per component
  logic [31:0] gm;
  logic [31:0] q;
  logic signed [64:0] u;
  logic [32:0] n;

  logic        sqrt_start, sqrt_busy;
  logic [32:0] sqrt_root;
  logic [65:0] d2;
  logic        div_start, div_busy;
  logic signed [63:0] div_num;
  logic [32:0] div_den;
  logic signed [64:0] div_quo;

  logic [1:0] pi, pj;
  logic [3:0] ci, cj, cb;
  logic signed [32:0] dx [3];
  logic signed [31:0] fsum;
  logic signed [63:0] pm;
  logic signed [63:0] vmul;

  always_comb begin
    case (cmd.pair)
      2'd0: begin pi = 2'd0; pj = 2'd1; end
      2'd1: begin pi = 2'd0; pj = 2'd2; end
      default: begin pi = 2'd1; pj = 2'd2; end
    endcase
    ci = 4'(pi) * 4'd3;
    cj = 4'(pj) * 4'd3;
    cb = 4'(cmd.body) * 4'd3 + 4'(cmd.comp);
    for (int k = 0; k < 3; k++) dx[k] = 33'(pos[ci + 4'(k)]) - 33'(pos[cj + 4'(k)]);
  end

  // sum of squares of the saturated differences
  always_comb begin
    logic signed [31:0] s [3];
    for (int k = 0; k < 3; k++) s[k] = sat32(66'(dx[k]));
    d2 = 66'(64'(s[0]) * 64'(s[0])) + 66'(64'(s[1]) * 64'(s[1]))
       + 66'(64'(s[2]) * 64'(s[2]));
  end

  // force sums for the selected body and component
  always_comb begin
    logic signed [65:0] t;
    case (cmd.body)
      2'd0: t = 66'(f[0][cmd.comp]) + 66'(f[1][cmd.comp]);
      2'd1: t = -66'(f[0][cmd.comp]) + 66'(f[2][cmd.comp]);
      default: t = -66'(f[1][cmd.comp]) - 66'(f[2][cmd.comp]);
    endcase
    fsum = sat32(t);
  end

  always_comb begin
    div_num = '0;
    div_den = n;
    case (cmd.dsel)
      DS_Q1: div_num = 64'(gm) <<< FRAC_BITS;
      DS_Q2: div_num = 64'(q) <<< FRAC_BITS;
      DS_U:  div_num = 64'(r[cmd.comp]) <<< FRAC_BITS;
      DS_A: begin
        div_num = 64'(fsum) <<< FRAC_BITS;
        div_den = 33'(mass[cmd.body]);
      end
      default: div_num = '0;
    endcase
  end

  assign sqrt_start = (cmd.op == OP_PAIR);
  assign div_start  = (cmd.op == OP_DIV) || (cmd.op == OP_ACC);

  tbg_sqrt u_sqrt (.clk, .rst, .start(sqrt_start), .radicand(d2),
                   .busy(sqrt_busy), .root(sqrt_root));
  tbg_div u_div (.clk, .rst, .start(div_start), .num(div_num), .den(div_den),
                 .busy(div_busy), .quo(div_quo));

  assign stat.sqrt_busy = sqrt_busy;
  assign stat.div_busy  = div_busy;
  assign stat.n_zero    = (sqrt_root == '0);

  // shared multiplier operands
  always_comb begin
    logic signed [32:0] a, b;
    a = '0;
    b = '0;
    case (cmd.op)
      OP_GM1:  begin a = 33'(grav_const); b = 33'(mass[pi]); end
      OP_GM2:  begin a = 33'(gm);        b = 33'(mass[pj]); end
      OP_FMUL: begin a = 33'(u[32:0]);   b = 33'(q); end
      OP_VEL:  begin a = 33'(acc[cb]);   b = 33'(dt); end
      OP_POS:  begin a = 33'(vel[cb]);   b = 33'(dt); end
      default: begin a = '0; b = '0; end
    endcase
    pm = 64'(a) * 64'(b);
    // bias negative products so the shift truncates toward zero
    vmul = (pm[63] ? pm + ((64'sd1 <<< FRAC_BITS) - 64'sd1) : pm) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NCOORD; k++) begin
        pos[k] <= init_pos(4'(k));
        vel[k] <= init_vel(4'(k));
      end
      last_time  <= '0;
      mass[0]    <= 31'(1 << FRAC_BITS);
      mass[1]    <= 31'(2 << FRAC_BITS);
      mass[2]    <= 31'(3 << FRAC_BITS);
      grav_const <= GRAV_RESET;
      stop_time  <= 31'(60 << FRAC_BITS);
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          REG_MASS0: mass[0]    <= cfg_data;
          REG_MASS1: mass[1]    <= cfg_data;
          REG_MASS2: mass[2]    <= cfg_data;
          REG_GRAV:  grav_const <= cfg_data;
          REG_STOP:  stop_time  <= cfg_data;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_START: begin
          tin <= elapsed_time;
          dt  <= sat32(66'(elapsed_time) - 66'(last_time));
          fin <= elapsed_time >= $signed({1'b0, stop_time});
        end
        OP_PAIR: begin
          for (int k = 0; k < 3; k++) r[k] <= sat32(66'(dx[k]));
          for (int k = 0; k < 3; k++) f[cmd.pair][k] <= '0;
        end
        OP_GM1: gm <= (vmul > 64'sh7fffffff) ? 32'h7fffffff : vmul[31:0];
        OP_GM2: begin
          gm <= (vmul > 64'sh7fffffff) ? 32'h7fffffff : vmul[31:0];
          n  <= sqrt_root;
        end
        OP_FMUL: f[cmd.pair][cmd.comp] <= sat32(-66'(vmul));
        OP_VEL: vel[cb] <= sat32(66'(vel[cb]) + 66'(vmul));
        OP_POS: begin
          pos[cb] <= sat32(66'(pos[cb]) + 66'(vmul));
          if (cb == 4'd8) last_time <= tin;
        end
        default: ;
      endcase
      // divider results land when the sequencer moves on
      if (cmd.op == OP_NOP && !div_busy) begin
        case (cmd.dsel)
          DS_Q1, DS_Q2: q <= (div_quo > 65'sh7fffffff) ? 32'h7fffffff : div_quo[31:0];
          DS_U: u <= div_quo;
          DS_A: acc[cb] <= (mass[cmd.body] == '0) ? '0 : sat32(66'(div_quo));
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      pos_b[b] = pos[4'(cmd.body) * 4'd3 + 4'(b)];
      acc_b[b] = acc[4'(cmd.body) * 4'd3 + 4'(b)];
    end
  end
endmodule
`default_nettype wire

// ===== sv/tbg_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbg_ctrl
// sequencer for one step: pair forces, accelerations, integration, output
// ----------------------------------------------------------------------------
`default_nettype none
module tbg_ctrl import tbg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output cmd_t       cmd,
  output logic [1:0] out_body
);
  typedef enum logic [3:0] {
    S_IDLE, S_PAIR, S_SQW, S_GM1, S_GM2, S_Q1, S_Q1W, S_Q2, S_Q2W,
    S_U, S_UW, S_FMUL, S_ACC, S_ACCW, S_INT, S_OUT
  } state_t;

  state_t     state;
  logic [1:0] pair, body, comp;
  logic       vphase;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_body  = body;

  always_comb begin
    cmd.op = OP_NOP;
    cmd.pair = pair;
    cmd.body = body;
    cmd.comp = comp;
    cmd.dsel = DS_Q1;
    case (state)
      S_IDLE: if (in_valid) cmd.op = OP_START;
      S_PAIR: cmd.op = OP_PAIR;
      S_GM1:  cmd.op = OP_GM1;
      S_GM2:  cmd.op = OP_GM2;
      S_Q1:   begin cmd.op = OP_DIV; cmd.dsel = DS_Q1; end
      S_Q1W:  cmd.dsel = DS_Q1;
      S_Q2:   begin cmd.op = OP_DIV; cmd.dsel = DS_Q2; end
      S_Q2W:  cmd.dsel = DS_Q2;
      S_U:    begin cmd.op = OP_DIV; cmd.dsel = DS_U; end
      S_UW:   cmd.dsel = DS_U;
      // a coincident pair keeps the forces cleared at pair load
      S_FMUL: cmd.op = stat.n_zero ? OP_NOP : OP_FMUL;
      S_ACC:  begin cmd.op = OP_ACC; cmd.dsel = DS_A; end
      S_ACCW: cmd.dsel = DS_A;
      S_INT:  cmd.op = vphase ? OP_POS : OP_VEL;
      S_OUT:  cmd.dsel = DS_NONE;
      default: cmd.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pair   <= '0;
      body   <= '0;
      comp   <= '0;
      vphase <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          state <= S_PAIR;
          pair  <= '0;
          body  <= '0;
          comp  <= '0;
        end
        S_PAIR: state <= S_SQW;
        S_SQW:  if (!stat.sqrt_busy) state <= stat.n_zero ? S_FMUL : S_GM1;
        S_GM1:  state <= S_GM2;
        S_GM2:  state <= S_Q1;
        S_Q1:   state <= S_Q1W;
        S_Q1W:  if (!stat.div_busy) state <= S_Q2;
        S_Q2:   state <= S_Q2W;
        S_Q2W:  if (!stat.div_busy) begin state <= S_U; comp <= '0; end
        S_U:    state <= S_UW;
        S_UW:   if (!stat.div_busy) state <= S_FMUL;
        S_FMUL: begin
          // zero distance skips straight here with forces already cleared
          if (comp == 2'd2 || stat.n_zero) begin
            comp <= '0;
            if (pair == 2'd2) begin state <= S_ACC; body <= '0; end
            else begin pair <= pair + 2'd1; state <= S_PAIR; end
          end else begin
            comp <= comp + 2'd1;
            state <= S_U;
          end
        end
        S_ACC:  state <= S_ACCW;
        S_ACCW: if (!stat.div_busy) begin
          if (comp == 2'd2) begin
            comp <= '0;
            if (body == 2'd2) begin
              state <= S_INT; body <= '0; vphase <= 1'b0;
            end else begin body <= body + 2'd1; state <= S_ACC; end
          end else begin comp <= comp + 2'd1; state <= S_ACC; end
        end
        S_INT: begin
          if (!vphase) vphase <= 1'b1;
          else begin
            vphase <= 1'b0;
            if (comp == 2'd2) begin
              comp <= '0;
              if (body == 2'd2) begin state <= S_OUT; body <= '0; end
              else body <= body + 2'd1;
            end else comp <= comp + 2'd1;
          end
        end
        S_OUT: if (out_ready) begin
          if (body == 2'd2) state <= S_IDLE;
          else body <= body + 2'd1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while results pending");
  a_body_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> body != 2'd3) else $error("bad body index");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(body))
    else $error("result dropped");
endmodule
`default_nettype wire

// ===== sv/three_body_gravity_step.sv =====
// ----------------------------------------------------------------------------
// three_body_gravity_step
// semi-implicit euler step of three bodies under pairwise gravity, q16.16
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       elapsed_time
// out       output     out_valid / out_ready     body_index, pos, acc, flags
// cfg       input      cfg_en                    cfg_index, cfg_data
//
// one item yields three output beats; its run time is set by the single
// shared divider (24 divides per step) and the square root run once per
// pair; a coincident pair skips its divides. reset loads the initial
// bodies and register defaults at once. the block takes one item at a
// time; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
module three_body_gravity_step import tbg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_en,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [30:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] elapsed_time,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              body_index,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      pos_z,
  output logic signed [31:0]      acc_x,
  output logic signed [31:0]      acc_y,
  output logic signed [31:0]      acc_z,
  output logic                    last_of_step,
  output logic                    finished
);
  cmd_t  cmd;
  stat_t stat;
  logic signed [31:0] pos_b [3];
  logic signed [31:0] acc_b [3];

  tbg_ctrl u_ctrl (.clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
                   .stat, .cmd, .out_body(body_index));
  tbg_datapath u_dp (.clk, .rst, .cfg_en, .cfg_index, .cfg_data, .elapsed_time,
                     .cmd, .stat, .pos_b, .acc_b, .fin(finished));

  assign pos_x = pos_b[0];
  assign pos_y = pos_b[1];
  assign pos_z = pos_b[2];
  assign acc_x = acc_b[0];
  assign acc_y = acc_b[1];
  assign acc_z = acc_b[2];
  assign last_of_step = (body_index == 2'd2);
endmodule
`default_nettype wire
